FILE: hdl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // channel width and scales
    localparam int unsigned CH_W        = 12;
    localparam int unsigned FULL_SCALE  = 4095;
    localparam int unsigned HALF_SECTOR = 1365;   // half-hue steps in one sector
    localparam int unsigned RR_W        = 11;     // remainder inside a sector
    localparam int unsigned TWO_HUE_W   = CH_W + 1;

    // blend denominator FULL_SCALE * HALF_SECTOR and the products on it
    localparam int unsigned     BLEND_W   = 23;
    localparam longint unsigned BLEND_DEN = 64'(FULL_SCALE) * 64'(HALF_SECTOR);
    localparam int unsigned     Y_W       = CH_W + BLEND_W;

    // floor(m / HALF_SECTOR) = (m * RECIP) >> RECIP_SHIFT for m < 2**BLEND_W
    localparam int unsigned     RECIP_SHIFT = 34;
    localparam int unsigned     RECIP_W     = 24;
    localparam longint unsigned RECIP       =
        ((64'd1 << RECIP_SHIFT) + 64'(HALF_SECTOR) - 64'd1) / 64'(HALF_SECTOR);

    // queue between classifier and datapath
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;

    // hue sectors, named by the hues they span
    typedef enum logic [2:0] {
        SECT_RY,    // red to yellow
        SECT_YG,    // yellow to green
        SECT_GC,    // green to cyan
        SECT_CB,    // cyan to blue
        SECT_BM,    // blue to magenta
        SECT_MR     // magenta to red
    } t_sector;

    // classified transaction
    typedef struct packed {
        t_sector            sector;
        logic [RR_W-1:0]    rr;
        logic [CH_W-1:0]    sat;
        logic [CH_W-1:0]    bri;
    } t_item;

endpackage

FILE: hdl/hsvrgb_if.sv
`timescale 1ns / 1ps

interface hsvrgb_hsv_if import hsvrgb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    hue;
    logic [CH_W-1:0]    saturation;
    logic [CH_W-1:0]    brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface hsvrgb_rgb_if import hsvrgb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hdl/hsvrgb_front.sv
`timescale 1ns / 1ps

module hsvrgb_front import hsvrgb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hsvrgb_hsv_if.sink      i_hsv,
    output logic            o_push_vld,
    output t_item           o_push_item,
    input  logic            i_push_rdy
);

    localparam logic [TWO_HUE_W-1:0] BND1 = TWO_HUE_W'(1 * HALF_SECTOR);
    localparam logic [TWO_HUE_W-1:0] BND2 = TWO_HUE_W'(2 * HALF_SECTOR);
    localparam logic [TWO_HUE_W-1:0] BND3 = TWO_HUE_W'(3 * HALF_SECTOR);
    localparam logic [TWO_HUE_W-1:0] BND4 = TWO_HUE_W'(4 * HALF_SECTOR);
    localparam logic [TWO_HUE_W-1:0] BND5 = TWO_HUE_W'(5 * HALF_SECTOR);
    localparam logic [TWO_HUE_W-1:0] BND6 = TWO_HUE_W'(6 * HALF_SECTOR);

    logic                   r_vld;
    t_item                  r_item;
    t_item                  n_item;
    logic [TWO_HUE_W-1:0]   two_hue;
    logic [TWO_HUE_W-1:0]   sect_base;

    // sector by parallel compares; top of scale wraps to the first sector
    always_comb begin
        two_hue = {i_hsv.hue, 1'b0};
        if (two_hue < BND1) begin
            n_item.sector = SECT_RY;
            sect_base     = '0;
        end else if (two_hue < BND2) begin
            n_item.sector = SECT_YG;
            sect_base     = BND1;
        end else if (two_hue < BND3) begin
            n_item.sector = SECT_GC;
            sect_base     = BND2;
        end else if (two_hue < BND4) begin
            n_item.sector = SECT_CB;
            sect_base     = BND3;
        end else if (two_hue < BND5) begin
            n_item.sector = SECT_BM;
            sect_base     = BND4;
        end else if (two_hue < BND6) begin
            n_item.sector = SECT_MR;
            sect_base     = BND5;
        end else begin
            n_item.sector = SECT_RY;
            sect_base     = BND6;
        end
        n_item.rr  = RR_W'(two_hue - sect_base);
        n_item.sat = i_hsv.saturation;
        n_item.bri = i_hsv.brightness;
    end

    assign i_hsv.ready = !r_vld || i_push_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_hsv.ready) begin
            r_vld <= i_hsv.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hsv.valid && i_hsv.ready) begin
            r_item <= n_item;
        end
    end

    assign o_push_vld  = r_vld;
    assign o_push_item = r_item;

endmodule

FILE: hdl/hsvrgb_queue.sv
`timescale 1ns / 1ps

module hsvrgb_queue import hsvrgb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_vld,
    input  t_item   i_push_item,
    output logic    o_push_rdy,
    output logic    o_pop_vld,
    output t_item   o_pop_item,
    input  logic    i_pop_rdy
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr;
    logic [Q_AW:0]      r_cnt;
    logic               push;
    logic               pop;

    assign o_push_rdy = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_vld  = (r_cnt != '0);
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;
    assign o_pop_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: hdl/hsvrgb_back.sv
`timescale 1ns / 1ps

module hsvrgb_back import hsvrgb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  t_item           i_item,
    output logic            o_rdy,
    hsvrgb_rgb_if.source    o_rgb
);

    localparam logic [BLEND_W-1:0] DEN = BLEND_W'(BLEND_DEN);
    localparam logic [RECIP_W-1:0] RCP = RECIP_W'(RECIP);
    localparam logic [RR_W-1:0]    HS  = RR_W'(HALF_SECTOR);
    localparam logic [CH_W-1:0]    FS  = CH_W'(FULL_SCALE);
    localparam int unsigned        PR_W = BLEND_W + RECIP_W;

    typedef struct packed {
        t_sector            sector;
        logic [BLEND_W-1:0] xq;
        logic [BLEND_W-1:0] xt;
        logic [CH_W-1:0]    ps;
        logic [CH_W-1:0]    bri;
    } t_st1;

    typedef struct packed {
        t_sector            sector;
        logic [Y_W-1:0]     yq;
        logic [Y_W-1:0]     yt;
        logic [Y_W-1:0]     yp;
        logic [CH_W-1:0]    bri;
    } t_st2;

    typedef struct packed {
        t_sector            sector;
        logic [BLEND_W-1:0] mq;
        logic [BLEND_W-1:0] mt;
        logic [CH_W-1:0]    p;
        logic [CH_W-1:0]    bri;
    } t_st3;

    typedef struct packed {
        t_sector            sector;
        logic [CH_W-1:0]    q;
        logic [CH_W-1:0]    t;
        logic [CH_W-1:0]    p;
        logic [CH_W-1:0]    bri;
    } t_st4;

    // floor(y / 4095): fold 12-bit digits twice, then one compare
    function automatic logic [BLEND_W-1:0] div_fs(input logic [Y_W-1:0] y);
        logic [BLEND_W:0]   z;
        logic [CH_W-1:0]    c;
        logic [CH_W:0]      w;
        logic [BLEND_W:0]   sum;
        z   = (BLEND_W+1)'(y[Y_W-1:CH_W]) + (BLEND_W+1)'(y[CH_W-1:0]);
        c   = z[BLEND_W:CH_W];
        w   = (CH_W+1)'(c) + (CH_W+1)'(z[CH_W-1:0]);
        sum = (BLEND_W+1)'(y[Y_W-1:CH_W]) + (BLEND_W+1)'(c)
            + (BLEND_W+1)'(w >= (CH_W+1)'(FULL_SCALE));
        return BLEND_W'(sum);
    endfunction

    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic               en1, en2, en3, en4, en5;
    t_st1               r_s1, n_s1;
    t_st2               r_s2, n_s2;
    t_st3               r_s3, n_s3;
    t_st4               r_s4, n_s4;
    logic [CH_W-1:0]    r_red, r_green, r_blue;
    logic [CH_W-1:0]    n_red, n_green, n_blue;
    logic [RR_W-1:0]    rr_c;
    logic [BLEND_W-1:0] sq, st;
    logic [PR_W-1:0]    prod_q, prod_t;

    // each stage loads when empty or when the next one moves
    assign en5   = !r_v5 || o_rgb.ready;
    assign en4   = !r_v4 || en5;
    assign en3   = !r_v3 || en4;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_rdy = en1;

    // stage 1: saturation times sector fraction
    always_comb begin
        rr_c      = HS - i_item.rr;
        sq        = BLEND_W'(i_item.sat) * BLEND_W'(i_item.rr);
        st        = BLEND_W'(i_item.sat) * BLEND_W'(rr_c);
        n_s1.sector = i_item.sector;
        n_s1.xq   = DEN - sq;
        n_s1.xt   = DEN - st;
        n_s1.ps   = FS - i_item.sat;
        n_s1.bri  = i_item.bri;
    end

    // stage 2: scale by brightness
    always_comb begin
        n_s2.sector = r_s1.sector;
        n_s2.yq   = Y_W'(r_s1.bri) * Y_W'(r_s1.xq);
        n_s2.yt   = Y_W'(r_s1.bri) * Y_W'(r_s1.xt);
        n_s2.yp   = Y_W'(r_s1.bri) * Y_W'(r_s1.ps);
        n_s2.bri  = r_s1.bri;
    end

    // stage 3: divide by full scale
    always_comb begin
        n_s3.sector = r_s2.sector;
        n_s3.mq   = div_fs(r_s2.yq);
        n_s3.mt   = div_fs(r_s2.yt);
        n_s3.p    = CH_W'(div_fs(r_s2.yp));
        n_s3.bri  = r_s2.bri;
    end

    // stage 4: divide by half sector via reciprocal
    always_comb begin
        prod_q    = PR_W'(r_s3.mq) * PR_W'(RCP);
        prod_t    = PR_W'(r_s3.mt) * PR_W'(RCP);
        n_s4.sector = r_s3.sector;
        n_s4.q    = prod_q[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
        n_s4.t    = prod_t[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
        n_s4.p    = r_s3.p;
        n_s4.bri  = r_s3.bri;
    end

    // stage 5: route levels to channels
    always_comb begin
        unique case (r_s4.sector)
            SECT_YG: begin
                n_red = r_s4.q;   n_green = r_s4.bri; n_blue = r_s4.p;
            end
            SECT_GC: begin
                n_red = r_s4.p;   n_green = r_s4.bri; n_blue = r_s4.t;
            end
            SECT_CB: begin
                n_red = r_s4.p;   n_green = r_s4.q;   n_blue = r_s4.bri;
            end
            SECT_BM: begin
                n_red = r_s4.t;   n_green = r_s4.p;   n_blue = r_s4.bri;
            end
            SECT_MR: begin
                n_red = r_s4.bri; n_green = r_s4.p;   n_blue = r_s4.q;
            end
            default: begin
                n_red = r_s4.bri; n_green = r_s4.t;   n_blue = r_s4.p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_vld;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_vld) r_s1 <= n_s1;
        if (en2 && r_v1)  r_s2 <= n_s2;
        if (en3 && r_v2)  r_s3 <= n_s3;
        if (en4 && r_v3)  r_s4 <= n_s4;
        if (en5 && r_v4) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_rgb.valid = r_v5;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

endmodule

FILE: hdl/hsv_to_rgb_12bit.sv
`timescale 1ns / 1ps

// channel  | dir | handshake    | payload
// ---------+-----+--------------+----------------------------------------
// i_hsv    | in  | valid/ready  | hue, saturation, brightness (12b each)
// o_rgb    | out | valid/ready  | red, green, blue (12b each)
//
// One transaction per cycle sustained while the output is ready; from accept to valid
// output a transaction passes the classify register at accept, a queue write,
// then 5 datapath stages, the last one being the output register.
// Synchronous active-low reset clears all valid flags and queue pointers.
// A stalled output backs up the datapath stage by stage; the 4-entry queue
// absorbs the difference so the input side keeps taking transactions until the queue is full.

module hsv_to_rgb_12bit import hsvrgb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hsvrgb_hsv_if.sink      i_hsv,
    hsvrgb_rgb_if.source    o_rgb
);

    // classifier -> queue
    logic   push_vld;
    t_item  push_item;
    logic   push_rdy;

    // queue -> datapath
    logic   pop_vld;
    t_item  pop_item;
    logic   pop_rdy;

    // front: sector and in-sector remainder from hue
    hsvrgb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hsv       (i_hsv),
        .o_push_vld  (push_vld),
        .o_push_item (push_item),
        .i_push_rdy  (push_rdy)
    );

    // decouples classifier from datapath stalls
    hsvrgb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (push_vld),
        .i_push_item (push_item),
        .o_push_rdy  (push_rdy),
        .o_pop_vld   (pop_vld),
        .o_pop_item  (pop_item),
        .i_pop_rdy   (pop_rdy)
    );

    // back: p/q/t levels and channel routing
    hsvrgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (pop_vld),
        .i_item  (pop_item),
        .o_rdy   (pop_rdy),
        .o_rgb   (o_rgb)
    );

endmodule
